### hw/rtl/smpe_pkg.sv
// ----------------------------------------------------------------------------
// smpe_pkg
// Shared types and constants of the serial mouse packet encoder.
// ----------------------------------------------------------------------------
package smpe_pkg;

  localparam int unsigned PACKET_LEN = 5;
  localparam int unsigned PIDX_W     = 3;
  localparam int unsigned POS_W      = 11;  // scaled position, offset*2
  localparam int unsigned LAST_W     = 12;
  localparam int unsigned CUR_W      = 10;
  localparam int unsigned SCALE_W    = 4;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned ADDR_W     = 5;

  localparam logic [7:0]  SYNC_BYTE   = 8'h80;
  localparam logic [7:0]  NO_DEVICE   = 8'hFF;
  localparam int          DELTA_LIMIT = 127;

  localparam logic [7:0]         BASE_PORT_RST = 8'h20;
  localparam logic [CUR_W-1:0]   WIN_X_LO_RST  = 10'd80;
  localparam logic [CUR_W:0]     WIN_X_HI_RST  = 11'd720;
  localparam logic [CUR_W-1:0]   WIN_Y_LO_RST  = 10'd60;
  localparam logic [CUR_W:0]     WIN_Y_HI_RST  = 11'd540;
  localparam logic [SCALE_W-1:0] SCALE_X_RST   = 4'd4;
  localparam logic [SCALE_W-1:0] SCALE_Y_RST   = 4'd3;

  typedef enum logic [2:0] {
    REG_BASE_PORT = 3'd0,
    REG_ENABLED   = 3'd1,
    REG_WIN_X_LO  = 3'd2,
    REG_WIN_X_HI  = 3'd3,
    REG_WIN_Y_LO  = 3'd4,
    REG_WIN_Y_HI  = 3'd5,
    REG_SCALE_X   = 3'd6,
    REG_SCALE_Y   = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_Y,
    ST_WAIT_Y,
    ST_START_X,
    ST_WAIT_X
  } state_e;

  typedef struct packed {
    logic [7:0]         base_port;
    logic               enabled;
    logic [CUR_W-1:0]   win_x_lo;
    logic [CUR_W:0]     win_x_hi;
    logic [CUR_W-1:0]   win_y_lo;
    logic [CUR_W:0]     win_y_hi;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] num;
    logic [SCALE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
  } div_rsp_t;

endpackage

### hw/rtl/serial_mouse_packet_encoder.sv
// ----------------------------------------------------------------------------
// serial_mouse_packet_encoder
// Emulated serial mouse: builds 5-byte sync/dx/dy packets from cursor events
// and hands them out byte by byte on port reads.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | sink      | in_valid_i / in_stall_o  | opcode, cursor_x/y, button_mask, port_address
//  out     | source    | out_valid_o / out_stall_i| read_data, irq_raise
//  cfg     | sink      | APB psel/penable/pwrite  | 8 registers at 4*index
//
//  A read that hands out a pending byte, a miss, or an event with a packet
//  pending is answered in the cycle after it is taken. A packet build runs
//  START_Y, WAIT_Y, START_X, WAIT_X (the shared serial divider runs 11 steps per
//  axis, y then x) and ends with its result beat; then the next beat can be taken.
//  Reset clears control state; packet bytes are always written before they
//  are read, so no clearing pass. Input is held off while a packet is built
//  or while the output beat is stalled.
// ----------------------------------------------------------------------------
module serial_mouse_packet_encoder import smpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [CUR_W-1:0]  cursor_x_i,
  input  logic [CUR_W-1:0]  cursor_y_i,
  input  logic [2:0]        button_mask_i,
  input  logic [7:0]        port_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        read_data_o,
  output logic              irq_raise_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e state_q, state_d;

  logic [CUR_W-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [2:0]        btn_q, btn_d;
  logic [LAST_W-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic [7:0]        sync_q, sync_d, dx_q, dx_d, ndy_q, ndy_d;
  logic [PIDX_W-1:0] pidx_q, pidx_d;
  logic              is_read_q, is_read_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;
  logic              out_irq_q, out_irq_d;

  logic accept, out_free, idle, hit, need_build, axis_x, div_start;

  smpe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  smpe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign idle       = (state_q == ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign hit        = cfg.enabled && (port_address_i == cfg.base_port);
  assign need_build = (pidx_q == '0) &&
                      ((opcode_e'(opcode_i) == OP_EVENT) || hit);

  // ---------------- axis operands: clamp, offset, scale divisor ----------------
  logic [CUR_W-1:0]   a_cur, a_lo, a_v, a_off;
  logic [CUR_W:0]     a_hi;
  logic [SCALE_W-1:0] a_scale;
  logic [LAST_W-1:0]  a_last, a_last_new;

  always_comb begin
    a_cur   = axis_x ? cur_x_q      : cur_y_q;
    a_lo    = axis_x ? cfg.win_x_lo : cfg.win_y_lo;
    a_hi    = axis_x ? cfg.win_x_hi : cfg.win_y_hi;
    a_scale = axis_x ? cfg.scale_x  : cfg.scale_y;
    a_last  = axis_x ? last_x_q     : last_y_q;
    if (a_cur < a_lo) begin
      a_v = a_lo;
    end else if ({1'b0, a_cur} >= a_hi) begin
      a_v = CUR_W'(a_hi - 1'b1);
    end else begin
      a_v = a_cur;
    end
    // degenerate window gives offset zero
    a_off = (a_hi <= {1'b0, a_lo}) ? '0 : (a_v - a_lo);
  end

  assign div_req.start = div_start;
  assign div_req.num   = {a_off, 1'b0};
  assign div_req.den   = (a_scale == '0) ? SCALE_W'(1) : a_scale;

  // ---------------- delta step against last reported position ----------------
  logic signed [LAST_W:0] diff;
  logic [7:0]             delta;

  assign diff = $signed({2'b00, div_rsp.quot}) - $signed({1'b0, a_last});

  always_comb begin
    if (diff > (LAST_W+1)'(DELTA_LIMIT)) begin
      delta = 8'(DELTA_LIMIT);
    end else if (diff < -(LAST_W+1)'(DELTA_LIMIT)) begin
      delta = 8'(-DELTA_LIMIT);
    end else begin
      delta = diff[7:0];
    end
  end

  assign a_last_new = a_last + {{(LAST_W-8){delta[7]}}, delta};

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept && need_build) state_d = ST_START_Y;
      ST_START_Y: state_d = ST_WAIT_Y;
      ST_WAIT_Y:  if (div_rsp.done) state_d = ST_START_X;
      ST_START_X: state_d = ST_WAIT_X;
      ST_WAIT_X:  if (div_rsp.done) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    axis_x     = 1'b0;
    unique case (state_q)
      ST_IDLE:    in_stall_o = !out_free;
      ST_START_Y: div_start = 1'b1;
      ST_WAIT_Y:  axis_x = 1'b0;
      ST_START_X: begin
        div_start = 1'b1;
        axis_x    = 1'b1;
      end
      ST_WAIT_X:  axis_x = 1'b1;
      default:    in_stall_o = 1'b1;
    endcase
  end

  // ---------------- datapath ----------------
  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    btn_d       = btn_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    sync_d      = sync_q;
    dx_d        = dx_q;
    ndy_d       = ndy_q;
    pidx_d      = pidx_q;
    is_read_d   = is_read_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    out_irq_d   = out_irq_q;

    if (idle && accept) begin
      if (opcode_e'(opcode_i) == OP_EVENT) begin
        cur_x_d = cursor_x_i;
        cur_y_d = cursor_y_i;
        btn_d   = button_mask_i;
      end
      is_read_d = (opcode_e'(opcode_i) == OP_READ);
      if (!need_build) begin
        out_valid_d = 1'b1;
        out_data_d  = 8'd0;
        out_irq_d   = 1'b0;
        if (opcode_e'(opcode_i) == OP_READ) begin
          if (!hit) begin
            out_data_d = NO_DEVICE;
          end else begin
            case (pidx_q)
              PIDX_W'(1): out_data_d = sync_q;
              PIDX_W'(2): out_data_d = dx_q;
              PIDX_W'(3): out_data_d = ndy_q;
              default:    out_data_d = 8'd0;
            endcase
            if (pidx_q == PIDX_W'(PACKET_LEN)) begin
              pidx_d    = '0;
              out_irq_d = 1'b1;
            end else begin
              pidx_d = pidx_q + 1'b1;
            end
          end
        end
      end
    end

    if ((state_q == ST_WAIT_Y) && div_rsp.done) begin
      last_y_d = a_last_new;
      ndy_d    = 8'd0 - delta;
    end

    if ((state_q == ST_WAIT_X) && div_rsp.done) begin
      last_x_d = a_last_new;
      dx_d     = delta;
      // buttons reordered to L,M,R in bits 2,1,0
      sync_d   = SYNC_BYTE | {5'd0, btn_q[0], btn_q[1], btn_q[2]};
      out_valid_d = 1'b1;
      out_irq_d   = 1'b1;
      out_data_d  = is_read_q ? sync_d : 8'd0;
      pidx_d      = is_read_q ? PIDX_W'(2) : PIDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_x_q     <= WIN_X_LO_RST;
      cur_y_q     <= WIN_Y_LO_RST;
      btn_q       <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      pidx_q      <= '0;
      is_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      btn_q       <= btn_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      pidx_q      <= pidx_d;
      is_read_q   <= is_read_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sync_q     <= sync_d;
    dx_q       <= dx_d;
    ndy_q      <= ndy_d;
    out_data_q <= out_data_d;
    out_irq_q  <= out_irq_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign irq_raise_o = out_irq_q;

endmodule

### hw/rtl/smpe_regs.sv
// ----------------------------------------------------------------------------
// smpe_regs
// APB-style configuration registers of the mouse packet encoder.
// ----------------------------------------------------------------------------
module smpe_regs import smpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_BASE_PORT: cfg_d.base_port = pwdata[7:0];
        REG_ENABLED:   cfg_d.enabled   = pwdata[0];
        REG_WIN_X_LO:  cfg_d.win_x_lo  = pwdata[CUR_W-1:0];
        REG_WIN_X_HI:  cfg_d.win_x_hi  = pwdata[CUR_W:0];
        REG_WIN_Y_LO:  cfg_d.win_y_lo  = pwdata[CUR_W-1:0];
        REG_WIN_Y_HI:  cfg_d.win_y_hi  = pwdata[CUR_W:0];
        REG_SCALE_X:   cfg_d.scale_x   = pwdata[SCALE_W-1:0];
        REG_SCALE_Y:   cfg_d.scale_y   = pwdata[SCALE_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE_PORT: prdata = {24'd0, cfg_q.base_port};
      REG_ENABLED:   prdata = {31'd0, cfg_q.enabled};
      REG_WIN_X_LO:  prdata = {{(32-CUR_W){1'b0}}, cfg_q.win_x_lo};
      REG_WIN_X_HI:  prdata = {{(31-CUR_W){1'b0}}, cfg_q.win_x_hi};
      REG_WIN_Y_LO:  prdata = {{(32-CUR_W){1'b0}}, cfg_q.win_y_lo};
      REG_WIN_Y_HI:  prdata = {{(31-CUR_W){1'b0}}, cfg_q.win_y_hi};
      REG_SCALE_X:   prdata = {{(32-SCALE_W){1'b0}}, cfg_q.scale_x};
      REG_SCALE_Y:   prdata = {{(32-SCALE_W){1'b0}}, cfg_q.scale_y};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_port <= BASE_PORT_RST;
      cfg_q.enabled   <= 1'b1;
      cfg_q.win_x_lo  <= WIN_X_LO_RST;
      cfg_q.win_x_hi  <= WIN_X_HI_RST;
      cfg_q.win_y_lo  <= WIN_Y_LO_RST;
      cfg_q.win_y_hi  <= WIN_Y_HI_RST;
      cfg_q.scale_x   <= SCALE_X_RST;
      cfg_q.scale_y   <= SCALE_Y_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hw/rtl/smpe_div.sv
// ----------------------------------------------------------------------------
// smpe_div
// Restoring serial divider, one quotient bit per cycle, shared by both axes.
// ----------------------------------------------------------------------------
module smpe_div import smpe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [CNT_W-1:0] STEPS = CNT_W'(POS_W);

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [POS_W-1:0]   sh_q, sh_d;
  logic [SCALE_W-1:0] rem_q, rem_d;
  logic [SCALE_W-1:0] den_q, den_d;
  logic [SCALE_W:0]   trial;
  logic               fits;

  // shift the next numerator bit into the partial remainder
  assign trial = {rem_q, sh_q[POS_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cnt_d = STEPS;
      sh_d  = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      sh_d   = {sh_q[POS_W-2:0], fits};
      rem_d  = fits ? SCALE_W'(trial - {1'b0, den_q}) : trial[SCALE_W-1:0];
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

endmodule
